@@ rtl/core/blls_pkg.sv @@
`timescale 1ns / 1ps

package blls_pkg;

	localparam int ActW  = 3;
	localparam int DataW = 32;
	localparam int StatW = 2;
	localparam int PosW  = 6;
	localparam int MaxResults = 64;

	localparam logic [ActW-1:0] ActPush       = 3'd0;
	localparam logic [ActW-1:0] ActPop        = 3'd1;
	localparam logic [ActW-1:0] ActPeekTop    = 3'd2;
	localparam logic [ActW-1:0] ActPeekBottom = 3'd3;
	localparam logic [ActW-1:0] ActDump       = 3'd4;

	localparam logic [StatW-1:0] StOk       = 2'd0;
	localparam logic [StatW-1:0] StOverflow = 2'd1;
	localparam logic [StatW-1:0] StEmpty    = 2'd2;

	localparam logic [1:0] RdTop    = 2'd0;
	localparam logic [1:0] RdBottom = 2'd1;
	localparam logic [1:0] RdDump   = 2'd2;

	typedef struct packed {
		logic             push_wr;
		logic             err_ld;
		logic [StatW-1:0] err_code;
		logic             rd_start;
		logic [1:0]       rd_mode;
		logic             cnt_dec;
		logic             rd_issue;
		logic             rd_load;
	} blls_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic rem_zero;
		logic out_free;
	} blls_stat_t;

endpackage

@@ rtl/core/blls_ram.sv @@
`timescale 1ns / 1ps

module blls_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/core/blls_ctrl.sv @@
`timescale 1ns / 1ps

module blls_ctrl
	import blls_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [ActW-1:0] action,
	input  blls_stat_t      stat,
	output blls_cmd_t       cmd
);

	localparam logic SIdle = 1'b0;
	localparam logic SBusy = 1'b1;

	logic state_q;
	logic state_d;
	logic pend_q;
	logic pend_d;
	logic accept;

	assign in_ready = (state_q == SIdle) && stat.out_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		pend_d  = pend_q;
		unique case (state_q)
			SIdle: begin
				if (accept) begin
					unique case (action)
						ActPush: begin
							if (stat.full) begin
								cmd.err_ld   = 1'b1;
								cmd.err_code = StOverflow;
							end else begin
								cmd.push_wr = 1'b1;
							end
						end
						ActPop, ActPeekTop, ActPeekBottom, ActDump: begin
							if (stat.empty) begin
								cmd.err_ld   = 1'b1;
								cmd.err_code = StEmpty;
							end else begin
								cmd.rd_start = 1'b1;
								cmd.cnt_dec  = (action == ActPop);
								if (action == ActPeekBottom) begin
									cmd.rd_mode = RdBottom;
								end else if (action == ActDump) begin
									cmd.rd_mode = RdDump;
								end else begin
									cmd.rd_mode = RdTop;
								end
								state_d = SBusy;
							end
						end
						default: begin
						end
					endcase
				end
			end
			SBusy: begin
				cmd.rd_load  = pend_q && stat.out_free;
				cmd.rd_issue = !stat.rem_zero && (!pend_q || cmd.rd_load);
				if (cmd.rd_issue) begin
					pend_d = 1'b1;
				end else if (cmd.rd_load) begin
					pend_d = 1'b0;
				end
				if (stat.rem_zero && cmd.rd_load) begin
					state_d = SIdle;
				end
			end
			default: begin
				state_d = SIdle;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SIdle;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SIdle) |-> !pend_q)
		else $error("pending read data while idle");

	a_busy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SBusy) |-> (pend_q || !stat.rem_zero))
		else $error("busy with no read left and none pending");

endmodule

@@ rtl/core/blls_dp.sv @@
`timescale 1ns / 1ps

module blls_dp
	import blls_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [DataW-1:0] push_value,
	input  blls_cmd_t               cmd,
	output blls_stat_t              stat,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic        [StatW-1:0] status,
	output logic signed [DataW-1:0] data_word,
	output logic        [PosW-1:0]  position,
	output logic                    last
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int RW   = $clog2(MaxResults + 1);
	localparam int CmpW = (CW > RW) ? CW : RW;

	logic [CW-1:0]    cnt_q;
	logic [AW-1:0]    idx_q;
	logic [RW-1:0]    rem_q;
	logic [PosW-1:0]  pend_pos_q;
	logic             pend_last_q;
	logic [AW-1:0]    top_idx;
	logic [RW-1:0]    dump_rem;
	logic [DataW-1:0] rd_data;

	logic             out_valid_q;
	logic [StatW-1:0] out_status_q;
	logic [DataW-1:0] out_data_q;
	logic [PosW-1:0]  out_pos_q;
	logic             out_last_q;

	blls_ram #(
		.Width(DataW),
		.Depth(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.push_wr),
		.wr_addr(AW'(cnt_q)),
		.wr_data(push_value),
		.rd_en  (cmd.rd_issue),
		.rd_addr(idx_q),
		.rd_data(rd_data)
	);

	assign top_idx  = AW'(cnt_q - CW'(1));
	assign dump_rem = (CmpW'(cnt_q) > CmpW'(MaxResults)) ? RW'(MaxResults) : RW'(cnt_q);

	assign stat.full     = (cnt_q == CW'(DEPTH));
	assign stat.empty    = (cnt_q == '0);
	assign stat.rem_zero = (rem_q == '0);
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push_wr) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.rd_start) begin
				unique case (cmd.rd_mode)
					RdBottom: begin
						idx_q <= '0;
						rem_q <= RW'(1);
					end
					RdDump: begin
						idx_q <= top_idx;
						rem_q <= dump_rem;
					end
					default: begin
						idx_q <= top_idx;
						rem_q <= RW'(1);
					end
				endcase
			end else if (cmd.rd_issue) begin
				idx_q <= idx_q - AW'(1);
				rem_q <= rem_q - RW'(1);
			end
			if (cmd.push_wr || cmd.err_ld || cmd.rd_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			pend_pos_q  <= PosW'(idx_q);
			pend_last_q <= (rem_q == RW'(1));
		end
		if (cmd.push_wr) begin
			out_status_q <= StOk;
			out_data_q   <= push_value;
			out_pos_q    <= PosW'(cnt_q);
			out_last_q   <= 1'b1;
		end else if (cmd.err_ld) begin
			out_status_q <= cmd.err_code;
			out_data_q   <= '0;
			out_pos_q    <= '0;
			out_last_q   <= 1'b1;
		end else if (cmd.rd_load) begin
			out_status_q <= StOk;
			out_data_q   <= rd_data;
			out_pos_q    <= pend_pos_q;
			out_last_q   <= pend_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign data_word = out_data_q;
	assign position  = out_pos_q;
	assign last      = out_last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CmpW'(cnt_q) <= CmpW'(DEPTH))
		else $error("fill count beyond depth");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_wr |-> !stat.full)
		else $error("push written into a full store");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_wr || cmd.err_ld || cmd.rd_load) |-> stat.out_free)
		else $error("output register overwritten while held");

	a_issue_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |-> !stat.rem_zero)
		else $error("read issued with none remaining");

endmodule

@@ rtl/core/bounded_lifo_stack.sv @@
// Bounded LIFO stack of signed 32-bit words, DEPTH entries deep.
// Input channel (in_valid/in_ready): action and push_value. Output channel
// (out_valid/out_ready): status, data_word, position, last.
// Push, overflow and empty-status results are registered the cycle after
// the item is taken. Pop and peeks read the word memory through its
// registered read port: a read is issued, then the word read is loaded
// into the output register. A dump streams one entry per cycle while the
// receiver takes them, from top to bottom, topmost 64 entries at most,
// last set on the final one. One item is in work at a time: in_ready is
// high only while no read is outstanding and the output register is empty
// or being taken, so push and error items sustain one per cycle while the
// receiver keeps up; a read action holds off input till its last word loads.
// A stalled receiver holds the output register and the stream; nothing is
// lost. Reset empties the stack at once; memory contents are not cleared.
// Unknown action codes are taken and give no result.
`timescale 1ns / 1ps

module bounded_lifo_stack
	import blls_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic        [ActW-1:0]  action,
	input  logic signed [DataW-1:0] push_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic        [StatW-1:0] status,
	output logic signed [DataW-1:0] data_word,
	output logic        [PosW-1:0]  position,
	output logic                    last
);

	blls_cmd_t  cmd;
	blls_stat_t stat;

	blls_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action  (action),
		.stat    (stat),
		.cmd     (cmd)
	);

	blls_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_value(push_value),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.data_word (data_word),
		.position  (position),
		.last      (last)
	);

endmodule
